@@ design/fixed_point_keypad_calculator_core_defines.svh @@
// Assertion macros shared by the calculator core.
`ifndef FIXED_POINT_KEYPAD_CALCULATOR_CORE_DEFINES_SVH
`define FIXED_POINT_KEYPAD_CALCULATOR_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define FPKC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define FPKC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/fpkc_pkg.sv @@
//------------------------------------------------------------------------------
// fpkc_pkg
// Shared types and constants of the keypad calculator core.
//------------------------------------------------------------------------------
`default_nettype none
package fpkc_pkg;
   localparam logic [3:0] KEY_DIGIT  = 4'd0;
   localparam logic [3:0] KEY_POINT  = 4'd1;
   localparam logic [3:0] KEY_ADD    = 4'd2;
   localparam logic [3:0] KEY_SUB    = 4'd3;
   localparam logic [3:0] KEY_MUL    = 4'd4;
   localparam logic [3:0] KEY_DIV    = 4'd5;
   localparam logic [3:0] KEY_EQUALS = 4'd6;
   localparam logic [3:0] KEY_CLEAR  = 4'd7;
   localparam logic [3:0] KEY_NEGATE = 4'd8;
   localparam logic [3:0] KEY_PCT    = 4'd9;

   localparam logic [2:0] PEND_NONE = 3'd0;
   localparam logic [2:0] PEND_ADD  = 3'd1;
   localparam logic [2:0] PEND_SUB  = 3'd2;
   localparam logic [2:0] PEND_MUL  = 3'd3;
   localparam logic [2:0] PEND_DIV  = 3'd4;

   localparam logic [63:0] SCALE       = 64'd100;
   localparam logic [63:0] ENTRY_LIMIT = 64'd999999999;

   // Datapath commands issued by the controller.
   localparam logic [3:0] CMD_NONE      = 4'd0;
   localparam logic [3:0] CMD_LOAD_KEY  = 4'd1;  // capture key, start decode
   localparam logic [3:0] CMD_MUL_START = 4'd2;  // accum * display
   localparam logic [3:0] CMD_DIV_START = 4'd3;  // start divider on prepared operands
   localparam logic [3:0] CMD_FINISH    = 4'd4;  // commit the key's effect
   localparam logic [3:0] CMD_STEP      = 4'd5;  // one iteration of the shared unit
   localparam logic [3:0] CMD_CLEAR     = 4'd6;

   localparam logic [1:0] DIVSRC_DISPLAY = 2'd0;  // display / 100
   localparam logic [1:0] DIVSRC_PRODUCT = 2'd1;  // product / 100
   localparam logic [1:0] DIVSRC_ACCUM   = 2'd2;  // accum*100 / display

   typedef struct packed {
      logic [3:0] cmd;
      logic [1:0] div_src;
   } ctl_type;

   typedef struct packed {
      logic [3:0] key;
      logic       need_mul;
      logic       need_div;
      logic [1:0] div_src;
      logic       unit_done;
   } sts_type;

   typedef struct packed {
      logic [63:0] shown_value;
      logic [63:0] stored_value;
      logic [2:0]  waiting_operator;
      logic        fresh_entry;
      logic        point_entered;
      logic [1:0]  fraction_count;
   } rsp_type;
endpackage
`default_nettype wire

@@ design/fpkc_if.sv @@
//------------------------------------------------------------------------------
// fpkc_req_if / fpkc_rsp_if
// Valid/ready channels for key items and state items.
//------------------------------------------------------------------------------
`default_nettype none
interface fpkc_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] op;
   logic [3:0] digit;
   modport source (output valid, output op, output digit, input ready);
   modport sink   (input valid, input op, input digit, output ready);
endinterface

interface fpkc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] shown_value;
   logic signed [63:0] stored_value;
   logic [2:0]         waiting_operator;
   logic               fresh_entry;
   logic               point_entered;
   logic [1:0]         fraction_count;
   modport source (output valid, output shown_value, output stored_value,
                   output waiting_operator, output fresh_entry,
                   output point_entered, output fraction_count, input ready);
   modport sink   (input valid, input shown_value, input stored_value,
                   input waiting_operator, input fresh_entry,
                   input point_entered, input fraction_count, output ready);
endinterface
`default_nettype wire

@@ design/fixed_point_keypad_calculator_core.sv @@
// Simple keys pass through decode, finish and response; clear skips finish.
// Digit, percent and an applied pending divide (nonzero divisor) also run
// the divider, and equals or an operator with a pending multiply runs the
// shared 64-step shift-add multiplier and then the restoring divider.
// One key item at a time; the state item is held until taken.
// Synchronous active-high reset clears all calculator state to zero.
//------------------------------------------------------------------------------
// fixed_point_keypad_calculator_core
// Four-function fixed-point calculator on keypad items, values scaled by 100.
//------------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_keypad_calculator_core_defines.svh"
module fixed_point_keypad_calculator_core import fpkc_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   fpkc_req_if.sink  req,
   fpkc_rsp_if.source rsp
);
   ctl_type ctl;
   sts_type sts;
   rsp_type st;

   fpkc_control u_control (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .sts(sts), .ctl(ctl)
   );

   fpkc_datapath u_datapath (
      .clock(clock), .reset(reset),
      .key_op(req.op), .key_digit(req.digit),
      .ctl(ctl), .sts(sts), .state(st)
   );

   assign rsp.shown_value = st.shown_value;
   assign rsp.stored_value = st.stored_value;
   assign rsp.waiting_operator = st.waiting_operator;
   assign rsp.fresh_entry = st.fresh_entry;
   assign rsp.point_entered = st.point_entered;
   assign rsp.fraction_count = st.fraction_count;

   `FPKC_ASSERT(a_no_accept_while_busy, clock, reset, !(req.ready && rsp.valid), "accept during response")
   `FPKC_ASSERT(a_frac_range, clock, reset, st.fraction_count != 2'd3, "fraction count out of range")
   `FPKC_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(st), "response dropped")
endmodule
`default_nettype wire

@@ design/fpkc_datapath.sv @@
//------------------------------------------------------------------------------
// fpkc_datapath
// Calculator registers, a shift-add multiplier and a restoring divider that
// share one iteration counter.
//------------------------------------------------------------------------------
`default_nettype none
module fpkc_datapath import fpkc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [3:0] key_op,
   input  wire logic [3:0] key_digit,
   input  wire ctl_type    ctl,
   output sts_type         sts,
   output rsp_type         state
);
   logic [63:0] disp_ff, disp_in, acc_ff, acc_in;
   logic [2:0]  pend_ff, pend_in;
   logic        fresh_ff, fresh_in, point_ff, point_in;
   logic [1:0]  frac_ff, frac_in;
   logic [3:0]  key_ff, key_in, dig_ff, dig_in;
   // Shared iterative unit.
   logic [63:0] a_ff, a_in;      // multiplicand, or dividend magnitude shifting out
   logic [63:0] b_ff, b_in;      // multiplier, or divisor magnitude
   logic [63:0] r_ff, r_in;      // product or partial remainder
   logic [63:0] q_ff, q_in;      // quotient
   logic        qneg_ff, qneg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_mul_ff, busy_mul_in, busy_div_ff, busy_div_in;
   logic [63:0] quo_signed;
   logic [64:0] rem_sh, rem_sub;
   logic [63:0] mag_d, whole, ent_mag, ent_val;
   logic [63:0] div_a, div_b;
   logic [63:0] acc_scaled;
   logic        div_neg, unit_done;

   function automatic logic [63:0] mag_of(input logic [63:0] v);
      mag_of = v[63] ? (64'd0 - v) : v;
   endfunction

   assign quo_signed = qneg_ff ? (64'd0 - q_ff) : q_ff;
   assign rem_sh  = {r_ff, a_ff[63]};
   assign rem_sub = rem_sh - {1'b0, b_ff};
   assign unit_done = (cnt_ff == 7'd0) && !busy_mul_ff && !busy_div_ff;

   // The dividend's sign is that of the wrapped scaled accumulator.
   assign acc_scaled = acc_ff * SCALE;

   // Digit entry: magnitude of the display after the new-number clear.
   assign mag_d = fresh_ff ? 64'd0 : mag_of(disp_ff);
   assign whole = q_ff;  // mag_d / 100 computed by the divider before finish

   always_comb begin
      logic       neg;
      logic [1:0] fr;
      logic       pt;
      neg = fresh_ff ? 1'b0 : disp_ff[63];
      pt  = fresh_ff ? 1'b0 : point_ff;
      fr  = fresh_ff ? 2'd0 : frac_ff;
      ent_mag = mag_d;
      if (pt) begin
         if (fr == 2'd0)
            ent_mag = whole * SCALE + {60'd0, dig_ff} * 64'd10;
         else if (fr == 2'd1)
            ent_mag = mag_d + {60'd0, dig_ff};
      end else if (whole < ENTRY_LIMIT) begin
         ent_mag = (whole * 64'd10 + {60'd0, dig_ff}) * SCALE;
      end
      ent_val = neg ? (64'd0 - ent_mag) : ent_mag;
   end

   // Operands for the divider.
   always_comb begin
      div_a = mag_of(disp_ff);
      div_b = SCALE;
      div_neg = disp_ff[63];
      case (ctl.div_src)
         DIVSRC_DISPLAY: begin
            if (key_ff == KEY_DIGIT) begin
               div_a = mag_d;
               div_neg = 1'b0;
            end
         end
         DIVSRC_PRODUCT: begin
            div_a = mag_of(r_ff);
            div_neg = r_ff[63];
         end
         DIVSRC_ACCUM: begin
            div_a = mag_of(acc_scaled);
            div_b = mag_of(disp_ff);
            div_neg = acc_scaled[63] ^ disp_ff[63];
         end
         default: ;
      endcase
   end

   always_comb begin
      logic apply;
      logic [63:0] acc_new;
      disp_in = disp_ff; acc_in = acc_ff; pend_in = pend_ff;
      fresh_in = fresh_ff; point_in = point_ff; frac_in = frac_ff;
      key_in = key_ff; dig_in = dig_ff;
      a_in = a_ff; b_in = b_ff; r_in = r_ff; q_in = q_ff; qneg_in = qneg_ff;
      cnt_in = cnt_ff; busy_mul_in = busy_mul_ff; busy_div_in = busy_div_ff;
      apply = 1'b0;
      acc_new = acc_ff;
      case (ctl.cmd)
         CMD_LOAD_KEY: begin
            key_in = key_op;
            dig_in = key_digit;
         end
         CMD_MUL_START: begin
            a_in = acc_ff; b_in = disp_ff; r_in = 64'd0;
            cnt_in = 7'd64; busy_mul_in = 1'b1;
         end
         CMD_DIV_START: begin
            a_in = div_a; b_in = div_b; r_in = 64'd0; q_in = 64'd0;
            qneg_in = div_neg; cnt_in = 7'd64; busy_div_in = 1'b1;
         end
         CMD_STEP: begin
            if (busy_mul_ff) begin
               // One bit of the multiplier per cycle, low bit first.
               if (b_ff[0]) r_in = r_ff + a_ff;
               a_in = {a_ff[62:0], 1'b0};
               b_in = {1'b0, b_ff[63:1]};
            end else if (busy_div_ff) begin
               a_in = {a_ff[62:0], 1'b0};
               if (!rem_sub[64]) begin
                  r_in = rem_sub[63:0];
                  q_in = {q_ff[62:0], 1'b1};
               end else begin
                  r_in = rem_sh[63:0];
                  q_in = {q_ff[62:0], 1'b0};
               end
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_mul_in = 1'b0;
               busy_div_in = 1'b0;
            end
         end
         CMD_FINISH: begin
            // Result of the pending operation, from the unit where needed.
            case (pend_ff)
               PEND_NONE: acc_new = disp_ff;
               PEND_ADD:  acc_new = acc_ff + disp_ff;
               PEND_SUB:  acc_new = acc_ff - disp_ff;
               PEND_MUL:  acc_new = quo_signed;
               PEND_DIV:  acc_new = (disp_ff != 64'd0) ? quo_signed : acc_ff;
               default:   acc_new = acc_ff;
            endcase
            case (key_ff)
               KEY_DIGIT: begin
                  disp_in = ent_val;
                  fresh_in = 1'b0;
                  point_in = fresh_ff ? 1'b0 : point_ff;
                  frac_in = fresh_ff ? 2'd0 : frac_ff;
                  if ((fresh_ff ? 1'b0 : point_ff) && (frac_in != 2'd2))
                     frac_in = frac_in + 2'd1;
               end
               KEY_POINT: begin
                  if (fresh_ff) begin
                     disp_in = 64'd0; fresh_in = 1'b0; frac_in = 2'd0;
                  end
                  point_in = 1'b1;
               end
               KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
                  apply = !fresh_ff;
                  pend_in = key_ff[2:0] - 3'd1;
                  fresh_in = 1'b1; point_in = 1'b0; frac_in = 2'd0;
               end
               KEY_EQUALS: begin
                  apply = 1'b1;
                  pend_in = PEND_NONE;
                  fresh_in = 1'b1; point_in = 1'b0; frac_in = 2'd0;
               end
               KEY_NEGATE: disp_in = 64'd0 - disp_ff;
               KEY_PCT:    disp_in = quo_signed;
               default: ;
            endcase
            if (apply) begin
               acc_in = acc_new;
               disp_in = acc_new;
            end
         end
         CMD_CLEAR: begin
            disp_in = 64'd0; acc_in = 64'd0; pend_in = PEND_NONE;
            fresh_in = 1'b0; point_in = 1'b0; frac_in = 2'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff <= '0; acc_ff <= '0; pend_ff <= PEND_NONE;
         fresh_ff <= 1'b0; point_ff <= 1'b0; frac_ff <= 2'd0;
         cnt_ff <= '0; busy_mul_ff <= 1'b0; busy_div_ff <= 1'b0;
      end else begin
         disp_ff <= disp_in; acc_ff <= acc_in; pend_ff <= pend_in;
         fresh_ff <= fresh_in; point_ff <= point_in; frac_ff <= frac_in;
         cnt_ff <= cnt_in; busy_mul_ff <= busy_mul_in; busy_div_ff <= busy_div_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in; dig_ff <= dig_in;
      a_ff <= a_in; b_ff <= b_in; r_ff <= r_in; q_ff <= q_in; qneg_ff <= qneg_in;
   end

   // Which unit work the current key calls for.
   always_comb begin
      logic op_key, applies;
      op_key = (key_ff == KEY_ADD) || (key_ff == KEY_SUB) ||
               (key_ff == KEY_MUL) || (key_ff == KEY_DIV);
      applies = (op_key && !fresh_ff) || (key_ff == KEY_EQUALS);
      sts.key = key_ff;
      sts.unit_done = unit_done;
      sts.need_mul = applies && (pend_ff == PEND_MUL);
      sts.need_div = 1'b0;
      sts.div_src = DIVSRC_DISPLAY;
      if (applies && (pend_ff == PEND_MUL)) begin
         sts.need_div = 1'b1; sts.div_src = DIVSRC_PRODUCT;
      end else if (applies && (pend_ff == PEND_DIV) && (disp_ff != 64'd0)) begin
         sts.need_div = 1'b1; sts.div_src = DIVSRC_ACCUM;
      end else if ((key_ff == KEY_PCT) || (key_ff == KEY_DIGIT)) begin
         sts.need_div = 1'b1; sts.div_src = DIVSRC_DISPLAY;
      end
   end

   assign state.shown_value = disp_ff;
   assign state.stored_value = acc_ff;
   assign state.waiting_operator = pend_ff;
   assign state.fresh_entry = fresh_ff;
   assign state.point_entered = point_ff;
   assign state.fraction_count = frac_ff;
endmodule
`default_nettype wire

@@ design/fpkc_control.sv @@
//------------------------------------------------------------------------------
// fpkc_control
// Sequencer for one key item: decode, multiply, divide, commit, respond.
//------------------------------------------------------------------------------
`default_nettype none
module fpkc_control import fpkc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   output logic      out_valid,
   input  wire logic out_ready,
   input  wire sts_type sts,
   output ctl_type   ctl
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIVGO  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] src_ff, src_in;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      src_in = src_ff;
      ctl.cmd = CMD_NONE;
      ctl.div_src = src_ff;
      case (state_ff)
         ST_IDLE: if (in_valid) begin
            ctl.cmd = CMD_LOAD_KEY;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            src_in = sts.div_src;
            if (sts.key == KEY_CLEAR) begin
               ctl.cmd = CMD_CLEAR;
               state_in = ST_RESP;
            end else if (sts.need_mul) begin
               ctl.cmd = CMD_MUL_START;
               state_in = ST_MUL;
            end else if (sts.need_div) begin
               state_in = ST_DIVGO;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MUL: begin
            ctl.cmd = CMD_STEP;
            if (sts.unit_done) begin
               ctl.cmd = CMD_NONE;
               state_in = ST_DIVGO;
            end
         end
         ST_DIVGO: begin
            ctl.cmd = CMD_DIV_START;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ctl.cmd = CMD_STEP;
            if (sts.unit_done) begin
               ctl.cmd = CMD_NONE;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ctl.cmd = CMD_FINISH;
            state_in = ST_RESP;
         end
         ST_RESP: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         src_ff <= DIVSRC_DISPLAY;
      end else begin
         state_ff <= state_in;
         src_ff <= src_in;
      end
   end
endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench
// Drives key items into the calculator core under varying idle and stall
// patterns and compares every state item with a local fixed-point predictor.
//------------------------------------------------------------------------------
module testbench import fpkc_pkg::*; ();

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   fpkc_req_if req_if ();
   fpkc_rsp_if rsp_if ();

   fixed_point_keypad_calculator_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   typedef struct packed {
      logic [3:0] op;
      logic [3:0] digit;
   } key_item_type;

   key_item_type key_queue[$];
   rsp_type      state_queue[$];

   // Predictor state.
   logic [63:0] calc_display, calc_accum;
   logic [2:0]  calc_pending;
   logic        calc_fresh, calc_point;
   logic [1:0]  calc_frac;

   int send_idle_pct, recv_stall_pct;
   int long_hold;
   bit pause_send;
   int mismatch_count;
   longint cycle_count;

   function automatic logic [63:0] mag_of(logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] trunc_div(logic [63:0] a, logic [63:0] b);
      logic [63:0] q;
      q = mag_of(a) / mag_of(b);
      return (a[63] != b[63]) ? (64'd0 - q) : q;
   endfunction

   function automatic void fold_pending();
      case (calc_pending)
         PEND_NONE: calc_accum = calc_display;
         PEND_ADD:  calc_accum = calc_accum + calc_display;
         PEND_SUB:  calc_accum = calc_accum - calc_display;
         PEND_MUL:  calc_accum = trunc_div(calc_accum * calc_display, SCALE);
         PEND_DIV:  if (calc_display != 64'd0)
                       calc_accum = trunc_div(calc_accum * SCALE, calc_display);
         default: ;
      endcase
   endfunction

   function automatic void calc_clear();
      calc_display = '0; calc_accum = '0; calc_pending = PEND_NONE;
      calc_fresh = 1'b0; calc_point = 1'b0; calc_frac = '0;
   endfunction

   function automatic void press_op(logic [2:0] code);
      if (!calc_fresh) begin
         fold_pending();
         calc_display = calc_accum;
      end
      calc_pending = code;
      calc_fresh = 1'b1; calc_point = 1'b0; calc_frac = '0;
   endfunction

   function automatic rsp_type predict_key(key_item_type k);
      rsp_type r;
      logic neg;
      logic [63:0] m, whole, d;
      d = {60'd0, k.digit};
      case (k.op)
         KEY_DIGIT: begin
            if (calc_fresh) begin
               calc_display = '0; calc_fresh = 1'b0; calc_point = 1'b0; calc_frac = '0;
            end
            neg = calc_display[63];
            m = mag_of(calc_display);
            if (calc_point) begin
               if (calc_frac < 2'd2) begin
                  calc_frac = calc_frac + 2'd1;
                  if (calc_frac == 2'd1) m = (m / SCALE) * SCALE + d * 64'd10;
                  else m = m + d;
                  calc_display = neg ? (64'd0 - m) : m;
               end
            end else begin
               whole = m / SCALE;
               if (whole < ENTRY_LIMIT) begin
                  m = (whole * 64'd10 + d) * SCALE;
                  calc_display = neg ? (64'd0 - m) : m;
               end
            end
         end
         KEY_POINT: begin
            if (calc_fresh) begin
               calc_display = '0; calc_fresh = 1'b0; calc_frac = '0;
            end
            calc_point = 1'b1;
         end
         KEY_ADD: press_op(PEND_ADD);
         KEY_SUB: press_op(PEND_SUB);
         KEY_MUL: press_op(PEND_MUL);
         KEY_DIV: press_op(PEND_DIV);
         KEY_EQUALS: begin
            fold_pending();
            calc_display = calc_accum;
            calc_pending = PEND_NONE;
            calc_fresh = 1'b1; calc_point = 1'b0; calc_frac = '0;
         end
         KEY_CLEAR:  calc_clear();
         KEY_NEGATE: calc_display = 64'd0 - calc_display;
         KEY_PCT:    calc_display = trunc_div(calc_display, SCALE);
         default: ;
      endcase
      r.shown_value = calc_display;
      r.stored_value = calc_accum;
      r.waiting_operator = calc_pending;
      r.fresh_entry = calc_fresh;
      r.point_entered = calc_point;
      r.fraction_count = calc_frac;
      return r;
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.op <= '0;
         req_if.digit <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid && req_if.ready)
            state_queue.push_back(predict_key(key_item_type'({req_if.op, req_if.digit})));
         if (key_queue.size() != 0 && !pause_send
             && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            {req_if.op, req_if.digit} <= key_queue.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver stall, with a separately counted long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (state_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected state item shown=%0d", rsp_if.shown_value);
         end else begin
            want = state_queue.pop_front();
            if (want.shown_value !== rsp_if.shown_value
                || want.stored_value !== rsp_if.stored_value
                || want.waiting_operator !== rsp_if.waiting_operator
                || want.fresh_entry !== rsp_if.fresh_entry
                || want.point_entered !== rsp_if.point_entered
                || want.fraction_count !== rsp_if.fraction_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp %0d %0d %0d %0b %0b %0d got %0d %0d %0d %0b %0b %0d",
                     $signed(want.shown_value), $signed(want.stored_value),
                     want.waiting_operator, want.fresh_entry, want.point_entered,
                     want.fraction_count, rsp_if.shown_value, rsp_if.stored_value,
                     rsp_if.waiting_operator, rsp_if.fresh_entry,
                     rsp_if.point_entered, rsp_if.fraction_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 3000000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic add_key(logic [3:0] op, logic [3:0] digit);
      key_queue.push_back(key_item_type'({op, digit}));
   endtask

   task automatic wait_drained();
      while (key_queue.size() != 0 || req_if.valid || state_queue.size() != 0)
         @(posedge clock);
   endtask

   // Weighted random key: mostly digits and operators so sums actually form.
   task automatic add_random_key();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         add_key(KEY_DIGIT, (pick < 42) ? 4'($urandom_range(9)) : 4'($urandom_range(15)));
      else if (pick < 52) add_key(KEY_POINT, 4'($urandom_range(15)));
      else if (pick < 74) add_key(KEY_ADD + 4'($urandom_range(3)), 4'($urandom_range(15)));
      else if (pick < 84) add_key(KEY_EQUALS, 4'($urandom_range(15)));
      else if (pick < 87) add_key(KEY_CLEAR, 4'($urandom_range(15)));
      else if (pick < 92) add_key(KEY_NEGATE, 4'($urandom_range(15)));
      else if (pick < 97) add_key(KEY_PCT, 4'($urandom_range(15)));
      else                add_key(4'($urandom_range(15, 10)), 4'($urandom_range(15)));
   endtask

   initial begin
      send_idle_pct = 0; recv_stall_pct = 0; long_hold = 0; pause_send = 1'b0;
      mismatch_count = 0; cycle_count = 0;
      calc_clear();
      req_if.valid = 1'b0; req_if.op = '0; req_if.digit = '0; rsp_if.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: entry limit, fractions, every operator, divide by zero.
      repeat (10) add_key(KEY_DIGIT, 4'd9);
      add_key(KEY_POINT, 4'd0); add_key(KEY_DIGIT, 4'd7); add_key(KEY_DIGIT, 4'd5);
      add_key(KEY_DIGIT, 4'd3);
      add_key(KEY_NEGATE, 4'd0); add_key(KEY_MUL, 4'd0); add_key(KEY_DIGIT, 4'd15);
      add_key(KEY_DIV, 4'd0); add_key(KEY_DIGIT, 4'd0); add_key(KEY_EQUALS, 4'd0);
      add_key(KEY_SUB, 4'd0); add_key(KEY_DIGIT, 4'd3); add_key(KEY_ADD, 4'd0);
      add_key(KEY_PCT, 4'd0); add_key(KEY_EQUALS, 4'd0); add_key(4'd15, 4'd15);
      add_key(KEY_CLEAR, 4'd0);
      wait_drained();

      // Doubling 1.00 wraps through -2^63 to zero; then percent and a digit.
      add_key(KEY_DIGIT, 4'd1); add_key(KEY_EQUALS, 4'd0);
      repeat (63) begin
         add_key(KEY_ADD, 4'd0); add_key(KEY_EQUALS, 4'd0);
      end
      add_key(KEY_PCT, 4'd0); add_key(KEY_DIGIT, 4'd5); add_key(KEY_CLEAR, 4'd0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 48 : 17) : 0;
         recv_stall_pct = (phase == 2) ? 48 : (phase == 3 ? 17 : 0);
         if (phase == 2) long_hold = 2000;
         repeat (170) add_random_key();
         wait_drained();
      end

      // The sender is held off while these keys queue up, then let go.
      pause_send = 1'b1;
      repeat (30) add_random_key();
      repeat (50) @(posedge clock);
      pause_send = 1'b0;
      wait_drained();

      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && state_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
